[hdl/snr_squelch_hysteresis_hang_assert.svh]
// Assertion macros for the SNR squelch block.
// Used by the checker module only; depends on nothing else.
`ifndef SNR_SQUELCH_HYSTERESIS_HANG_ASSERT_SVH
`define SNR_SQUELCH_HYSTERESIS_HANG_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("squelch assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("squelch assertion failed");

`endif

[hdl/sqh_pkg.sv]
// Shared types and constants for the SNR squelch block.
// Used by every other file of the block but the assertion macro header; depends on nothing.
package sqh_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MaxBlockDefault   = 4096;
  localparam int unsigned SampleBitsDefault = 16;

  // Fixed field widths.
  localparam int unsigned LenW     = 13;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned HangW    = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegEnable = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOpen   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegClose  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegHang   = 8'd3;

  // Register reset values.
  localparam logic              EnableRst = 1'b1;
  localparam logic [RatioW-1:0] OpenRst   = 16'd2560;
  localparam logic [RatioW-1:0] CloseRst  = 16'd1615;
  localparam logic [HangW-1:0]  HangRst   = 16'd12000;

  // Which product the shared multiplier forms.
  typedef enum logic [1:0] {
    MulSig   = 2'd0,
    MulTot   = 2'd1,
    MulOpen  = 2'd2,
    MulClose = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic              enable;
    logic [RatioW-1:0] open_ratio;
    logic [RatioW-1:0] close_ratio;
    logic [HangW-1:0]  hang_samples;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     sq_first;
    logic     sq_second;
    logic     root_start;
    logic     root_step;
    logic     accum;
    logic     mul_start;
    logic     mul_step;
    logic     mul_store;
    mul_sel_e mul_sel;
    logic     finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_done;
    logic mul_done;
    logic block_last;
    logic out_free;
  } stat_t;

endpackage

[hdl/sqh_if.sv]
// Handshake channels of the SNR squelch block: samples, results, register writes.
// Depends on sqh_pkg for the fixed field widths.
interface sqh_in_if #(
  parameter int unsigned SampleBits = sqh_pkg::SampleBitsDefault
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] in_phase;
  logic [SampleBits-1:0] quadrature;
  logic                  block_end;

  modport source (output valid, in_phase, quadrature, block_end, input ready);
  modport sink   (input valid, in_phase, quadrature, block_end, output ready);
endinterface

interface sqh_out_if;
  logic                      valid;
  logic                      ready;
  logic                      gate_open;
  logic                      above_open;
  logic                      below_close;
  logic [sqh_pkg::LenW-1:0]  block_length;

  modport source (output valid, gate_open, above_open, below_close, block_length,
                  input ready);
  modport sink   (input valid, gate_open, above_open, below_close, block_length,
                  output ready);
endinterface

interface sqh_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sqh_pkg::CfgIdxW-1:0]  index;
  logic [sqh_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/sqh_ctrl.sv]
// Controller state machine of the SNR squelch block.
// Depends on sqh_pkg for the command and status structs.
module sqh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sqh_pkg::stat_t stat_i,
  output sqh_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SSqI     = 4'd1;
  localparam logic [3:0] SSqQ     = 4'd2;
  localparam logic [3:0] SRootIni = 4'd3;
  localparam logic [3:0] SRoot    = 4'd4;
  localparam logic [3:0] SAcc     = 4'd5;
  localparam logic [3:0] SSigLd   = 4'd6;
  localparam logic [3:0] SSigRun  = 4'd7;
  localparam logic [3:0] STotLd   = 4'd8;
  localparam logic [3:0] STotRun  = 4'd9;
  localparam logic [3:0] SOpnLd   = 4'd10;
  localparam logic [3:0] SOpnRun  = 4'd11;
  localparam logic [3:0] SClsLd   = 4'd12;
  localparam logic [3:0] SClsRun  = 4'd13;
  localparam logic [3:0] SDone    = 4'd14;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = sqh_pkg::MulSig;
    unique case (state_q) inside
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = SSqI;
        end
      end
      SSqI: begin
        cmd_o.sq_first = 1'b1;
        state_d = SSqQ;
      end
      SSqQ: begin
        cmd_o.sq_second = 1'b1;
        state_d = SRootIni;
      end
      SRootIni: begin
        cmd_o.root_start = 1'b1;
        state_d = SRoot;
      end
      SRoot: begin
        if (stat_i.root_done) begin
          state_d = SAcc;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      SAcc: begin
        cmd_o.accum = 1'b1;
        state_d = stat_i.block_last ? SSigLd : SIdle;
      end
      SSigLd, STotLd, SOpnLd, SClsLd: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel = (state_q == SSigLd) ? sqh_pkg::MulSig :
                        (state_q == STotLd) ? sqh_pkg::MulTot :
                        (state_q == SOpnLd) ? sqh_pkg::MulOpen : sqh_pkg::MulClose;
        state_d = state_q + 4'd1;
      end
      SSigRun, STotRun, SOpnRun, SClsRun: begin
        cmd_o.mul_sel = (state_q == SSigRun) ? sqh_pkg::MulSig :
                        (state_q == STotRun) ? sqh_pkg::MulTot :
                        (state_q == SOpnRun) ? sqh_pkg::MulOpen : sqh_pkg::MulClose;
        if (stat_i.mul_done) begin
          cmd_o.mul_store = 1'b1;
          state_d = state_q + 4'd1;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      SDone: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/sqh_datapath.sv]
// Datapath of the SNR squelch block: magnitude, accumulators, shared multiplier,
// squelch state and result register. Depends on sqh_pkg.
module sqh_datapath #(
  parameter int unsigned MaxBlock   = sqh_pkg::MaxBlockDefault,
  parameter int unsigned SampleBits = sqh_pkg::SampleBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sqh_pkg::cmd_t            cmd_i,
  output sqh_pkg::stat_t           stat_o,
  input  sqh_pkg::cfg_t            cfg_i,
  input  logic [SampleBits-1:0]    in_phase_i,
  input  logic [SampleBits-1:0]    quadrature_i,
  input  logic                     block_end_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     gate_open_o,
  output logic                     above_open_o,
  output logic                     below_close_o,
  output logic [sqh_pkg::LenW-1:0] block_length_o
);

  localparam int unsigned SB   = SampleBits;
  localparam int unsigned CW   = $clog2(MaxBlock + 1);
  localparam int unsigned PW   = 2 * SB;
  localparam int unsigned S1W  = SB + CW;
  localparam int unsigned S2W  = PW + CW;
  localparam int unsigned SIGW = 2 * S1W;
  localparam int unsigned VW   = S2W + CW;
  localparam int unsigned MW   = (SIGW + 8 > VW + sqh_pkg::RatioW) ?
                                 (SIGW + 8) : (VW + sqh_pkg::RatioW);
  localparam int unsigned BW   = (S1W > sqh_pkg::RatioW) ? S1W : sqh_pkg::RatioW;
  localparam int unsigned RW   = SB + 3;
  localparam int unsigned RCW  = $clog2(SB + 1);
  localparam int unsigned XW   = (sqh_pkg::HangW > CW) ? sqh_pkg::HangW : CW;

  logic [SB-1:0]   ai_q, aq_q;
  logic            end_q;
  logic [PW-1:0]   p_q;
  logic [PW-1:0]   x_q;
  logic [RW-1:0]   rem_q;
  logic [SB-1:0]   root_q;
  logic [RCW-1:0]  rcnt_q;
  logic [S1W-1:0]  s1_q;
  logic [S2W-1:0]  s2_q;
  logic [CW-1:0]   n_q;
  logic [MW-1:0]   ma_q, macc_q;
  logic [BW-1:0]   mb_q;
  logic [SIGW-1:0] sig_q;
  logic [VW-1:0]   var_q;
  logic            var_zero_q, above_q, below_q;
  logic            open_q;
  logic [sqh_pkg::HangW-1:0] hang_q;
  logic            out_valid_q;

  // Magnitudes of the incoming sample in two's complement.
  logic [SB-1:0] ai_abs, aq_abs;
  assign ai_abs = in_phase_i[SB-1]   ? (~in_phase_i + SB'(1))   : in_phase_i;
  assign aq_abs = quadrature_i[SB-1] ? (~quadrature_i + SB'(1)) : quadrature_i;

  // One squarer shared by both components.
  logic [SB-1:0] sq_in;
  logic [PW-1:0] sq;
  assign sq_in = cmd_i.sq_second ? aq_q : ai_q;
  assign sq    = sq_in * sq_in;

  // Restoring square root, one result bit per cycle.
  logic [RW-1:0] rem_sh, trial;
  logic          take;
  assign rem_sh = {rem_q[RW-3:0], x_q[PW-1:PW-2]};
  assign trial  = RW'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);

  // Operand selection for the shared shift-add multiplier.
  logic [MW-1:0] op_a;
  logic [BW-1:0] op_b;
  always_comb begin
    case (cmd_i.mul_sel)
      sqh_pkg::MulSig: begin
        op_a = MW'(s1_q);
        op_b = BW'(s1_q);
      end
      sqh_pkg::MulTot: begin
        op_a = MW'(s2_q);
        op_b = BW'(n_q);
      end
      sqh_pkg::MulOpen: begin
        op_a = MW'(var_q);
        op_b = BW'(cfg_i.open_ratio);
      end
      default: begin
        op_a = MW'(var_q);
        op_b = BW'(cfg_i.close_ratio);
      end
    endcase
  end

  // Signal term scaled by 256 for the Q8.8 ratios.
  logic [MW-1:0] sig_sh, sig_ext;
  assign sig_ext = MW'(sig_q);
  assign sig_sh  = sig_ext << 8;

  // Decision values for the block being finished.
  logic             above_f, below_f;
  logic [XW-1:0]    hang_ext, n_ext;
  logic [sqh_pkg::HangW-1:0] hang_dec;
  assign above_f  = var_zero_q | above_q;
  assign below_f  = ~var_zero_q & below_q;
  assign hang_ext = XW'(hang_q);
  assign n_ext    = XW'(n_q);
  assign hang_dec = (hang_ext > n_ext) ? sqh_pkg::HangW'(hang_ext - n_ext) : '0;

  assign stat_o.root_done  = (rcnt_q == '0);
  assign stat_o.mul_done   = (mb_q == '0);
  assign stat_o.block_last = end_q | (n_q == CW'(MaxBlock - 1));
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

  // Sample capture, squaring and square root (payload, no reset).
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ai_q  <= ai_abs;
      aq_q  <= aq_abs;
      end_q <= block_end_i;
    end
    if (cmd_i.sq_first) begin
      p_q <= sq;
    end else if (cmd_i.sq_second) begin
      p_q <= p_q + sq;
    end
    if (cmd_i.root_start) begin
      x_q    <= p_q;
      rem_q  <= '0;
      root_q <= '0;
      rcnt_q <= RCW'(SB);
    end else if (cmd_i.root_step) begin
      x_q    <= x_q << 2;
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[SB-2:0], take};
      rcnt_q <= rcnt_q - RCW'(1);
    end
  end

  // Shared multiplier and the block-end products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q   <= op_a;
      mb_q   <= op_b;
      macc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mb_q[0]) begin
        macc_q <= macc_q + ma_q;
      end
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_sel)
        sqh_pkg::MulSig: sig_q <= SIGW'(macc_q);
        sqh_pkg::MulTot: begin
          var_q      <= (macc_q > sig_ext) ? VW'(macc_q - sig_ext) : '0;
          var_zero_q <= (macc_q <= sig_ext);
        end
        sqh_pkg::MulOpen: above_q <= (sig_sh > macc_q);
        default:          below_q <= (sig_sh < macc_q);
      endcase
    end
  end

  // Block accumulators, squelch state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      n_q         <= '0;
      open_q      <= 1'b0;
      hang_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        s1_q <= s1_q + S1W'(root_q);
        s2_q <= s2_q + S2W'(p_q);
        n_q  <= n_q + CW'(1);
      end else if (cmd_i.finish) begin
        s1_q <= '0;
        s2_q <= '0;
        n_q  <= '0;
      end
      if (cmd_i.finish) begin
        if (!cfg_i.enable) begin
          open_q <= 1'b1;
        end else if (above_f) begin
          open_q <= 1'b1;
          hang_q <= cfg_i.hang_samples;
        end else if (hang_q != '0) begin
          hang_q <= hang_dec;
        end else if (below_f) begin
          open_q <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      gate_open_o    <= ~cfg_i.enable | above_f | (open_q & ~(hang_q == '0 & below_f));
      above_open_o   <= above_f;
      below_close_o  <= below_f;
      block_length_o <= sqh_pkg::LenW'(n_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/snr_squelch_hysteresis_hang.sv]
// SNR squelch with hysteresis and hang time. Each sample word is taken one at a
// time: magnitude is formed by a squarer, used for I and then Q, and a restoring
// square root that yields one bit per cycle; the next sample is taken only once
// the current one has been accumulated. A word with block_end set, or the
// MaxBlock-th sample, closes the block; four products then run on one shift-add
// multiplier at one multiplier bit per cycle, after which the result word is
// loaded into the output register as soon as that register is free. The output
// register lets the next block start while a result waits. Register writes are
// always accepted and should only be made while the block is idle.
module snr_squelch_hysteresis_hang #(
  parameter int unsigned MaxBlock   = sqh_pkg::MaxBlockDefault,
  parameter int unsigned SampleBits = sqh_pkg::SampleBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sqh_in_if.sink    sample_i,
  sqh_out_if.source result_o,
  sqh_cfg_if.sink   cfg_i
);

  sqh_pkg::cfg_t  cfg_q;
  sqh_pkg::cmd_t  cmd;
  sqh_pkg::stat_t stat;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= sqh_pkg::EnableRst;
      cfg_q.open_ratio   <= sqh_pkg::OpenRst;
      cfg_q.close_ratio  <= sqh_pkg::CloseRst;
      cfg_q.hang_samples <= sqh_pkg::HangRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sqh_pkg::RegEnable: cfg_q.enable       <= cfg_i.data[0];
        sqh_pkg::RegOpen:   cfg_q.open_ratio   <= cfg_i.data;
        sqh_pkg::RegClose:  cfg_q.close_ratio  <= cfg_i.data;
        sqh_pkg::RegHang:   cfg_q.hang_samples <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sqh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sqh_datapath #(
    .MaxBlock   (MaxBlock),
    .SampleBits (SampleBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_i          (cfg_q),
    .in_phase_i     (sample_i.in_phase),
    .quadrature_i   (sample_i.quadrature),
    .block_end_i    (sample_i.block_end),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .gate_open_o    (result_o.gate_open),
    .above_open_o   (result_o.above_open),
    .below_close_o  (result_o.below_close),
    .block_length_o (result_o.block_length)
  );

endmodule

[hdl/sqh_checker.sv]
// Port-level checker for the SNR squelch block, bound to the top level.
// Depends on sqh_pkg and the assertion macro header.
`include "snr_squelch_hysteresis_hang_assert.svh"

module sqh_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     gate_open_i,
  input logic                     above_open_i,
  input logic                     below_close_i,
  input logic [sqh_pkg::LenW-1:0] block_length_i
);

  // The whole result word, for the hold check.
  logic [sqh_pkg::LenW+2:0] out_word;
  assign out_word = {gate_open_i, above_open_i, below_close_i, block_length_i};

  // A stalled result word holds.
  `SQH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word))

  // Register writes never stall.
  `SQH_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

  // A sample keeps the block busy in the cycle after it is taken.
  `SQH_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A block above the open threshold always leaves the squelch open.
  `SQH_ASSERT_IMP(a_above_opens, clk_i, rst_ni, out_valid_i && above_open_i, gate_open_i)

endmodule

bind snr_squelch_hysteresis_hang sqh_checker u_sqh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .gate_open_i    (result_o.gate_open),
  .above_open_i   (result_o.above_open),
  .below_close_i  (result_o.below_close),
  .block_length_i (result_o.block_length)
);
